// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PHCAL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PHCAL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PHCAL_ASSERT_IMP(lbl, ante, cons)
`define PHCAL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/phcal_pkg.sv -----
// shared types and constants of the ph calibration block
package phcal_pkg;
  localparam int SAMPLE_W = 24;
  localparam int TEMP_W = 15;
  localparam int SUM_W = 32;
  localparam int CNT_W = 8;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 36;
  localparam int DIV_QUO_W = 38;
  localparam int DIV_ITER_W = 7;

  localparam logic [14:0] KELVIN_CENTI = 15'd27315;
  localparam logic [19:0] UV_PER_V = 20'd1000000;
  localparam logic signed [17:0] TC_MIN = 18'sd100;
  localparam logic signed [39:0] PH_MAX = 40'sd8388607;
  localparam logic signed [39:0] PH_MIN = -40'sd8388608;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_READ_FAIL = 2'd1;
  localparam logic [1:0] ST_BAD_CAL = 2'd2;

  localparam logic [1:0] MODE_LT = 2'd1;
  localparam logic [1:0] MODE_LE = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_COUNT = 3'd1;
  localparam logic [2:0] REG_CAL_TEMP = 3'd2;
  localparam logic [2:0] REG_SLOPE_LO = 3'd3;
  localparam logic [2:0] REG_OFFSET_LO = 3'd4;
  localparam logic [2:0] REG_SLOPE_HI = 3'd5;
  localparam logic [2:0] REG_OFFSET_HI = 3'd6;
  localparam logic [2:0] REG_SPLIT = 3'd7;

  // queue entry from front to back
  typedef struct packed {
    logic                     fail;
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         cnt;
    logic signed [TEMP_W-1:0] temp;
  } ent_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_DEN_W-1:0]  den;
    logic [DIV_ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;
endpackage

// ----- sv/phcal_fifo.sv -----
// two-entry queue between front and back
module phcal_fifo import phcal_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ent_t push_data,
  input  logic pop,
  output ent_t head,
  output logic full,
  output logic empty
);
  ent_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head  = mem_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  // pointer and fill update
  always_comb begin
    wp_nxt  = wp_r + 1'b1;
    rp_nxt  = rp_r + 1'b1;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= wp_nxt;
      if (pop) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

// ----- sv/phcal_div.sv -----
// shared restoring divider, one quotient bit per cycle
module phcal_div import phcal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [DIV_DEN_W:0]    rem_r;
  logic [DIV_NUM_W-1:0]  num_r;
  logic [DIV_DEN_W-1:0]  den_r;
  logic [DIV_QUO_W-1:0]  quo_r;
  logic [DIV_ITER_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIV_DEN_W:0]    rem_sh;
  logic                  ge;
  logic [DIV_DEN_W:0]    rem_nxt;

  // one shift and subtract step
  always_comb begin
    rem_sh  = {rem_r[DIV_DEN_W-1:0], num_r[DIV_NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      num_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[DIV_NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_QUO_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

// ----- sv/phcal_front.sv -----
// front end: accumulates samples and queues finished rounds or failures
module phcal_front import phcal_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                     failed,
  input  logic signed [TEMP_W-1:0] temp,
  input  logic [CNT_W-1:0]         sample_count,
  input  logic                     full,
  output logic                     push,
  output ent_t                     push_data
);
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        need;
  logic                    acc;
  logic                    round_end;

  assign in_ready = !full;
  assign acc      = in_valid && !full;

  // accumulate and classify
  always_comb begin
    need      = (sample_count == '0) ? CNT_W'(1) : sample_count;
    sum_nxt   = sum_r + SUM_W'(sample);
    cnt_nxt   = cnt_r + 1'b1;
    round_end = (cnt_nxt >= need);
    push      = acc && (failed || round_end);
    push_data.fail = failed;
    push_data.sum  = sum_nxt;
    push_data.cnt  = cnt_nxt;
    push_data.temp = temp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (acc) begin
      if (failed || round_end) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end
endmodule

// ----- sv/phcal_back.sv -----
// back end: mean, compensation, division and the output register
`include "assert_macros.svh"
module phcal_back import phcal_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  ent_t               head,
  output logic               pop,
  input  logic [1:0]         mode,
  input  logic signed [15:0] cal_temp,
  input  logic signed [23:0] slope_low,
  input  logic signed [23:0] offset_low,
  input  logic signed [23:0] slope_high,
  input  logic signed [23:0] offset_high,
  input  logic signed [23:0] split_volts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_ph,
  output logic signed [23:0] out_avg,
  output logic [1:0]         out_status
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV1   = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_MUL3   = 4'd4;
  localparam logic [3:0] S_DIV2GO = 4'd5;
  localparam logic [3:0] S_DIV2   = 4'd6;
  localparam logic [3:0] S_SEND   = 4'd7;

  logic [3:0]          state_r, state_nxt;
  ent_t                ent_r;
  logic signed [23:0]  mean_r;
  logic [47:0]         p_r;
  logic                neg_r;
  logic signed [23:0]  off_r;
  logic [63:0]         acc_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic signed [23:0]  res_ph_r;
  logic signed [23:0]  res_avg_r;
  logic [1:0]          res_st_r;
  logic                out_valid_r;
  logic signed [23:0]  out_ph_r;
  logic signed [23:0]  out_avg_r;
  logic [1:0]          out_st_r;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic signed [17:0]  tc;
  logic                bad_cal;
  logic [16:0]         tm17;
  logic [15:0]         tm;
  logic [31:0]         sum_abs;
  logic [31:0]         mean_mag;
  logic signed [23:0]  mean_new;
  logic                low;
  logic signed [23:0]  slope_sel;
  logic [23:0]         s_abs;
  logic [23:0]         m_abs;
  logic signed [39:0]  q_s;
  logic signed [39:0]  ph_w;
  logic signed [23:0]  ph_sat;
  logic                out_free;

  phcal_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // temperatures in centikelvin
  always_comb begin
    tc      = 18'(cal_temp) + 18'(signed'({1'b0, KELVIN_CENTI}));
    bad_cal = (tc < TC_MIN);
    tm17    = 17'(ent_r.temp) + 17'(KELVIN_CENTI);
    tm      = tm17[15:0];
  end

  // mean from the first division
  always_comb begin
    sum_abs  = head.sum[SUM_W-1] ? 32'(-head.sum) : 32'(head.sum);
    mean_mag = div_rsp.quo[31:0];
    mean_new = ent_r.sum[SUM_W-1] ? 24'(-mean_mag) : 24'(mean_mag);
  end

  // line selection and magnitudes
  always_comb begin
    case (mode)
      MODE_LT: low = (mean_r < split_volts);
      MODE_LE: low = (mean_r <= split_volts);
      default: low = 1'b1;
    endcase
    slope_sel = low ? slope_low : slope_high;
    s_abs     = slope_sel[23] ? 24'(-slope_sel) : 24'(slope_sel);
    m_abs     = mean_r[23] ? 24'(-mean_r) : 24'(mean_r);
  end

  // signed quotient plus offset, saturated
  always_comb begin
    q_s  = neg_r ? -signed'({2'b0, div_rsp.quo}) : signed'({2'b0, div_rsp.quo});
    ph_w = q_s + 40'(off_r);
    if (ph_w > PH_MAX) ph_sat = PH_MAX[23:0];
    else if (ph_w < PH_MIN) ph_sat = PH_MIN[23:0];
    else ph_sat = ph_w[23:0];
  end

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {sum_abs, 32'b0};
    div_req.den   = DIV_DEN_W'(head.cnt);
    div_req.iters = DIV_ITER_W'(32);
    if (state_r == S_IDLE && !empty && !head.fail) begin
      div_req.start = 1'b1;
    end else if (state_r == S_DIV2GO) begin
      div_req.start = 1'b1;
      div_req.num   = acc_r;
      div_req.den   = den_r;
      div_req.iters = DIV_ITER_W'(64);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == S_IDLE) && !empty;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (!empty) state_nxt = head.fail ? S_SEND : S_DIV1;
      S_DIV1:   if (div_rsp.done) state_nxt = bad_cal ? S_SEND : S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_MUL3;
      S_MUL3:   state_nxt = S_DIV2GO;
      S_DIV2GO: state_nxt = S_DIV2;
      S_DIV2:   if (div_rsp.done) state_nxt = S_SEND;
      S_SEND:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SEND && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ent_r     <= head;
        res_ph_r  <= '0;
        res_avg_r <= '0;
        res_st_r  <= ST_READ_FAIL;
      end
      S_DIV1: begin
        mean_r    <= mean_new;
        res_avg_r <= mean_new;
        res_ph_r  <= '0;
        res_st_r  <= bad_cal ? ST_BAD_CAL : ST_OK;
      end
      S_MUL1: begin
        p_r   <= s_abs * m_abs;
        neg_r <= slope_sel[23] ^ mean_r[23];
        off_r <= low ? offset_low : offset_high;
      end
      S_MUL2: begin
        acc_r <= 64'(p_r[23:0] * tm);
        den_r <= DIV_DEN_W'(tc[16:0] * UV_PER_V);
      end
      S_MUL3: acc_r <= acc_r + (64'(p_r[47:24] * tm) << 24);
      S_DIV2: if (div_rsp.done) res_ph_r <= ph_sat;
      default: ;
    endcase
    if (state_r == S_SEND && out_free) begin
      out_ph_r  <= res_ph_r;
      out_avg_r <= res_avg_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ph     = out_ph_r;
  assign out_avg    = out_avg_r;
  assign out_status = out_st_r;

  `PHCAL_ASSERT_IMP(a_div_idle_start, div_req.start, !div_rsp.busy)
  `PHCAL_ASSERT_IMP(a_pop_nonempty, pop, !empty)
  `PHCAL_ASSERT_NXT(a_send_loads, (state_r == S_SEND) && out_free, out_valid_r)
endmodule

// ----- sv/ph_probe_averaging_calibration.sv -----
// top level: configuration registers, front end, queue and back end
// a finished round reaches out_tvalid through the queue handoff, the mean division,
//   the multiply steps S_MUL1 to S_MUL3 and the ph division
// a read failure skips both divisions and goes from the queue straight to the output register
// throughput: one input word per cycle while the two-entry queue has room,
//   the back end takes the next round from the queue only once it is back in idle
// reset: synchronous active-low rst_n clears sum, count, queue and configuration registers
module ph_probe_averaging_calibration import phcal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sample_uv[23:0], temp[38:24], zero pad
  input  logic        in_tuser,   // read_failed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // ph[23:0], avg_uv[47:24]
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  logic [1:0]         mode_r;
  logic [7:0]         count_r;
  logic signed [15:0] cal_temp_r;
  logic signed [23:0] slope_lo_r;
  logic signed [23:0] offset_lo_r;
  logic signed [23:0] slope_hi_r;
  logic signed [23:0] offset_hi_r;
  logic signed [23:0] split_r;

  logic               push;
  ent_t               push_data;
  logic               pop;
  ent_t               head;
  logic               full;
  logic               empty;
  logic signed [23:0] ph;
  logic signed [23:0] avg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 2'd0;
      count_r     <= 8'd1;
      cal_temp_r  <= 16'sd2500;
      slope_lo_r  <= -24'sd229376;
      offset_lo_r <= 24'sd458752;
      slope_hi_r  <= -24'sd229376;
      offset_hi_r <= 24'sd458752;
      split_r     <= 24'sd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:      mode_r      <= cfg_wdata[1:0];
        REG_COUNT:     count_r     <= cfg_wdata[7:0];
        REG_CAL_TEMP:  cal_temp_r  <= cfg_wdata[15:0];
        REG_SLOPE_LO:  slope_lo_r  <= cfg_wdata;
        REG_OFFSET_LO: offset_lo_r <= cfg_wdata;
        REG_SLOPE_HI:  slope_hi_r  <= cfg_wdata;
        REG_OFFSET_HI: offset_hi_r <= cfg_wdata;
        REG_SPLIT:     split_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  phcal_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .sample       (in_tdata[23:0]),
    .failed       (in_tuser),
    .temp         (in_tdata[38:24]),
    .sample_count (count_r),
    .full         (full),
    .push         (push),
    .push_data    (push_data)
  );

  phcal_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  phcal_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .mode        (mode_r),
    .cal_temp    (cal_temp_r),
    .slope_low   (slope_lo_r),
    .offset_low  (offset_lo_r),
    .slope_high  (slope_hi_r),
    .offset_high (offset_hi_r),
    .split_volts (split_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_ph      (ph),
    .out_avg     (avg),
    .out_status  (out_tuser)
  );

  assign out_tdata = {avg, ph};
endmodule
